// ===== src/sentence_boundary_marker_core_macros.svh =====
// Assertion macros used by the checker file of the sentence boundary marker.
`ifndef SENTENCE_BOUNDARY_MARKER_CORE_MACROS_SVH
`define SENTENCE_BOUNDARY_MARKER_CORE_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SBM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check a property on every rising clock edge, reset included.
`define SBM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/sbm_pkg.sv =====
// Types, character constants and the boundary decision function of the sentence boundary marker.
package sbm_pkg;

    // Character codes
    localparam logic [7:0] CH_PERIOD   = 8'h2E;
    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_BANG     = 8'h21;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_UPPER_M  = 8'h4D;
    localparam logic [7:0] CH_UPPER_D  = 8'h44;
    localparam logic [7:0] CH_UPPER_J  = 8'h4A;
    localparam logic [7:0] CH_LOWER_R  = 8'h72;
    localparam logic [7:0] CH_LOWER_S  = 8'h73;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CH_DIGIT_0  = 8'h30;
    localparam logic [7:0] CH_DIGIT_9  = 8'h39;

    // Window depth figures
    localparam int unsigned WIN_DEPTH = 3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       ends_sentence;
        logic       dropped;
        logic       last_out;
    } out_item_t;

    // Result handed from the window to the output register
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } res_xfer_t;

    // Window state: behind[0] is the newest decided byte, pending[0] the oldest undecided
    typedef struct packed {
        logic [WIN_DEPTH-1:0][7:0] behind;
        logic [WIN_DEPTH-1:0][7:0] pending;
        logic [1:0]                count;
        logic [1:0]                pos;
        logic                      run;
        logic                      skip;
    } win_state_t;

    typedef struct packed {
        win_state_t nxt;
        out_item_t  res;
    } decide_t;

    localparam win_state_t WIN_RESET = '0;

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_lower(logic [7:0] c);
        return (c >= CH_LOWER_A) && (c <= CH_LOWER_Z);
    endfunction

    function automatic logic is_upper(logic [7:0] c);
        return (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return is_lower(c) || is_upper(c);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
    endfunction

    function automatic logic is_mark(logic [7:0] c);
        return (c == CH_PERIOD) || (c == CH_QUESTION) || (c == CH_BANG);
    endfunction

    // Decide the oldest pending byte, produce its result and shift the window
    function automatic decide_t decide_step(win_state_t s, logic have1, logic have2);
        decide_t    d;
        logic [7:0] c;
        logic [7:0] n1;
        logic [7:0] n2;
        logic [7:0] p1;
        logic [7:0] p2;
        logic [7:0] p3;
        logic       next_period;
        logic       title;
        logic       rej;
        logic       ends;
        c  = s.pending[0];
        n1 = have1 ? s.pending[1] : 8'h00;
        n2 = have2 ? s.pending[2] : 8'h00;
        p1 = s.behind[0];
        p2 = s.behind[1];
        p3 = s.behind[2];
        next_period = have1 && (n1 == CH_PERIOD);

        // Mr. Dr. Jr. and Mrs. before a period
        title = ((s.pos >= 2'd2) && (p1 == CH_LOWER_R)
                 && ((p2 == CH_UPPER_M) || (p2 == CH_UPPER_D) || (p2 == CH_UPPER_J)))
             || ((s.pos == 2'd3) && (p3 == CH_UPPER_M) && (p2 == CH_LOWER_R)
                 && (p1 == CH_LOWER_S));

        rej = (have2 && is_space(n1) && is_lower(n2))
           || (have1 && is_digit(n1))
           || ((c == CH_PERIOD) && title)
           || (have1 && is_alpha(p1) && is_alpha(n1))
           || (have1 && (n1 == CH_COMMA));

        d    = '0;
        d.nxt = s;
        ends = 1'b0;
        if (s.run)
        begin
            if (!next_period)
            begin
                ends      = 1'b1;
                d.nxt.run = 1'b0;
            end
        end
        else if (is_mark(c) && (s.pos != 2'd0) && !rej)
        begin
            if (next_period)
                d.nxt.run = 1'b1;
            else
                ends = 1'b1;
        end

        d.res.out_byte      = c;
        d.res.ends_sentence = ends;
        d.res.dropped       = s.skip;
        d.res.last_out      = 1'b0;

        d.nxt.skip       = ends;
        d.nxt.behind[2]  = p2;
        d.nxt.behind[1]  = p1;
        d.nxt.behind[0]  = c;
        d.nxt.pos        = (s.pos == 2'd3) ? 2'd3 : s.pos + 2'd1;
        d.nxt.pending[0] = s.pending[1];
        d.nxt.pending[1] = s.pending[2];
        d.nxt.pending[2] = 8'h00;
        d.nxt.count      = (s.count != 2'd0) ? s.count - 2'd1 : 2'd0;
        return d;
    endfunction

endpackage

// ===== src/sbm_in_stage.sv =====
// Input register of the sentence boundary marker.
module sbm_in_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             text_valid,
    output logic             text_stall,
    input  sbm_pkg::in_item_t text_data,
    input  logic             take,
    output logic             held_valid,
    output sbm_pkg::in_item_t held_item
);
    import sbm_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    // Hold the current item until the window takes it
    assign text_stall = valid_reg && !take;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    // Load a new transfer whenever the register is free or being emptied
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!text_stall)
            valid_reg <= text_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!text_stall)
            item_reg <= text_data;
    end

endmodule

// ===== src/sbm_window.sv =====
// Byte window, boundary decision and end-of-text drain of the sentence boundary marker.
module sbm_window (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              held_valid,
    input  sbm_pkg::in_item_t held_item,
    output logic              take,
    input  logic              out_free,
    output sbm_pkg::res_xfer_t res
);
    import sbm_pkg::*;

    win_state_t st_reg;
    win_state_t st_next;
    logic       drain_reg;
    logic       drain_next;
    win_state_t pushed;
    win_state_t src;
    logic [1:0] push_idx;
    decide_t    dec;

    // Append the held byte to the pending bytes
    always_comb
    begin
        push_idx = (st_reg.count > 2'd2) ? 2'd2 : st_reg.count;
        pushed   = st_reg;
        pushed.pending[push_idx] = held_item.text_byte;
        pushed.count             = push_idx + 2'd1;
    end

    // One shared decision: drain works on the stored window, otherwise on the pushed one
    assign src = drain_reg ? st_reg : pushed;
    assign dec = decide_step(src, src.count >= 2'd2, src.count == 2'd3);

    assign take = held_valid && out_free && !drain_reg;

    // Advance the window and emit at most one result per cycle
    always_comb
    begin
        st_next    = st_reg;
        drain_next = drain_reg;
        res        = '0;
        res.item   = dec.res;
        if (out_free)
        begin
            if (drain_reg)
            begin
                res.valid         = 1'b1;
                res.item.last_out = (st_reg.count == 2'd1);
                if (st_reg.count == 2'd1)
                begin
                    st_next    = WIN_RESET;
                    drain_next = 1'b0;
                end
                else
                begin
                    st_next = dec.nxt;
                end
            end
            else if (held_valid)
            begin
                if (held_item.end_of_text)
                begin
                    res.valid         = 1'b1;
                    res.item.last_out = (pushed.count == 2'd1);
                    if (pushed.count == 2'd1)
                    begin
                        st_next = WIN_RESET;
                    end
                    else
                    begin
                        st_next    = dec.nxt;
                        drain_next = 1'b1;
                    end
                end
                else if (pushed.count == 2'd3)
                begin
                    res.valid = 1'b1;
                    st_next   = dec.nxt;
                end
                else
                begin
                    st_next = pushed;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= WIN_RESET;
            drain_reg <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            drain_reg <= drain_next;
        end
    end

endmodule

// ===== src/sbm_out_stage.sv =====
// Output register of the sentence boundary marker.
module sbm_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  sbm_pkg::res_xfer_t res,
    output logic               out_free,
    output logic               mark_valid,
    input  logic               mark_stall,
    output sbm_pkg::out_item_t mark_data
);
    import sbm_pkg::*;

    logic      valid_reg;
    out_item_t item_reg;

    // Free when empty or when the current result transfers this cycle
    assign out_free   = !valid_reg || !mark_stall;
    assign mark_valid = valid_reg;
    assign mark_data  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (out_free)
            valid_reg <= res.valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res.valid)
            item_reg <= res.item;
    end

endmodule

// ===== src/sentence_boundary_marker_core.sv =====
// Top level of the sentence boundary marker.
//
// Takes one text byte per cycle while the input is not stalled and returns each byte two bytes
// later with its sentence-end and dropped flags. An input transfer passes an input register, the
// window logic and an output register, so a result is registered in the output register when the
// window takes the transfer that completes it, and is offered from there. The window keeps two
// bytes of lookahead, so a byte's result leaves only once two more bytes have arrived; the byte
// marked end_of_text releases the remaining one to three results, one per cycle through the single
// decision unit while the output side does not stall, and the input stalls while they drain. The
// last of those carries last_out, after which the window is back in its reset state. Otherwise one
// byte is taken in every cycle that the output side does not stall.
module sentence_boundary_marker_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               text_valid,
    output logic               text_stall,
    input  sbm_pkg::in_item_t  text_data,
    output logic               mark_valid,
    input  logic               mark_stall,
    output sbm_pkg::out_item_t mark_data
);
    import sbm_pkg::*;

    logic      take;
    logic      held_valid;
    in_item_t  held_item;
    logic      out_free;
    res_xfer_t res;

    sbm_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text_data  (text_data),
        .take       (take),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    sbm_window u_win (
        .clk        (clk),
        .rst_n      (rst_n),
        .held_valid (held_valid),
        .held_item  (held_item),
        .take       (take),
        .out_free   (out_free),
        .res        (res)
    );

    sbm_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .res        (res),
        .out_free   (out_free),
        .mark_valid (mark_valid),
        .mark_stall (mark_stall),
        .mark_data  (mark_data)
    );

endmodule

// ===== src/sbm_checker.sv =====
// Port-level checker of the sentence boundary marker and its bind to the top level.
`include "sentence_boundary_marker_core_macros.svh"

module sbm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               text_valid,
    input logic               text_stall,
    input sbm_pkg::in_item_t  text_data,
    input logic               mark_valid,
    input logic               mark_stall,
    input sbm_pkg::out_item_t mark_data
);
    import sbm_pkg::*;

    logic mark_xfer;
    logic mark_held;
    logic text_held;
    logic mark_on_mark;
    logic mark_drop;
    logic drop_ok;
    logic prev_end_reg;
    logic prev_last_reg;

    assign mark_xfer    = mark_valid && !mark_stall;
    assign mark_held    = mark_valid && mark_stall;
    assign text_held    = text_valid && text_stall;
    assign mark_on_mark = is_mark(mark_data.out_byte);
    assign mark_drop    = mark_xfer && mark_data.dropped;
    assign drop_ok      = prev_end_reg && !prev_last_reg;

    // Track the flags of the previous result transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_end_reg  <= 1'b0;
            prev_last_reg <= 1'b0;
        end
        else if (mark_xfer)
        begin
            prev_end_reg  <= mark_data.ends_sentence;
            prev_last_reg <= mark_data.last_out;
        end
    end

    // A stalled result holds
    `SBM_ASSERT(a_mark_hold, mark_held |=> mark_valid && $stable(mark_data), "stalled result changed")

    // A stalled input transfer holds
    `SBM_ASSERT(a_text_hold, text_held |=> text_valid && $stable(text_data), "stalled input changed")

    // Input never stalls while the output register is empty
    `SBM_ASSERT_ALWAYS(a_no_idle_stall, !rst_n || mark_valid || !text_stall, "idle stall")

    // A sentence ends only on a mark character
    `SBM_ASSERT(a_end_on_mark, mark_valid && mark_data.ends_sentence |-> mark_on_mark, "end on non-mark")

    // A dropped byte directly follows a boundary within the same text
    `SBM_ASSERT(a_drop_after_end, mark_drop |-> drop_ok, "dropped byte without boundary")

endmodule

bind sentence_boundary_marker_core sbm_checker u_sbm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_data  (text_data),
    .mark_valid (mark_valid),
    .mark_stall (mark_stall),
    .mark_data  (mark_data)
);

// ===== bench/sentence_boundary_marker_core_tb.sv =====
// Self-checking testbench for the sentence boundary marker core.
`timescale 1ns / 1ps

module sentence_boundary_marker_core_tb;
    import sbm_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_REPORTS = 40;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      text_valid = 1'b0;
    logic      text_stall;
    in_item_t  text_data = '0;
    logic      mark_valid;
    logic      mark_stall = 1'b0;
    out_item_t mark_data;

    // Predicted window state
    logic [7:0]  back [3];
    logic [7:0]  ahead [3];
    int unsigned ahead_cnt;
    int unsigned pos_cnt;
    bit          period_run;
    bit          drop_next;

    out_item_t   expected_marks [$];
    logic [7:0]  text_buf [$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          idle_mode = 0;
    int          hold_left = 0;

    logic      seen_valid;
    logic      seen_stall;
    out_item_t seen_item;

    sentence_boundary_marker_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text_data  (text_data),
        .mark_valid (mark_valid),
        .mark_stall (mark_stall),
        .mark_data  (mark_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ASCII classes
    function automatic bit cls_space(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit cls_lower(logic [7:0] c);
        return c >= CH_LOWER_A && c <= CH_LOWER_Z;
    endfunction

    function automatic bit cls_alpha(logic [7:0] c);
        return cls_lower(c) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
    endfunction

    function automatic bit cls_digit(logic [7:0] c);
        return c >= CH_DIGIT_0 && c <= CH_DIGIT_9;
    endfunction

    function automatic bit cls_mark(logic [7:0] c);
        return c == CH_PERIOD || c == CH_QUESTION || c == CH_BANG;
    endfunction

    function automatic void clear_window();
        for (int i = 0; i < 3; i++)
        begin
            back[i]  = 8'h00;
            ahead[i] = 8'h00;
        end
        ahead_cnt  = 0;
        pos_cnt    = 0;
        period_run = 1'b0;
        drop_next  = 1'b0;
    endfunction

    // Settle the oldest undecided byte and shift the window by one
    function automatic out_item_t settle_oldest(bit have1, bit have2);
        out_item_t  r;
        logic [7:0] c;
        logic [7:0] n1;
        logic [7:0] n2;
        bit         follows_period;
        bit         after_title;
        bit         refused;
        bit         closes;
        c  = ahead[0];
        n1 = have1 ? ahead[1] : 8'h00;
        n2 = have2 ? ahead[2] : 8'h00;
        follows_period = have1 && n1 == CH_PERIOD;
        after_title = (pos_cnt >= 2 && back[0] == CH_LOWER_R
                       && (back[1] == CH_UPPER_M || back[1] == CH_UPPER_D
                           || back[1] == CH_UPPER_J))
                   || (pos_cnt >= 3 && back[2] == CH_UPPER_M && back[1] == CH_LOWER_R
                       && back[0] == CH_LOWER_S);
        refused = (have2 && cls_space(n1) && cls_lower(n2))
               || (have1 && cls_digit(n1))
               || (c == CH_PERIOD && after_title)
               || (have1 && cls_alpha(back[0]) && cls_alpha(n1))
               || (have1 && n1 == CH_COMMA);
        closes = 1'b0;
        if (period_run)
        begin
            if (!follows_period)
            begin
                closes     = 1'b1;
                period_run = 1'b0;
            end
        end
        else if (cls_mark(c) && pos_cnt != 0 && !refused)
        begin
            if (follows_period)
                period_run = 1'b1;
            else
                closes = 1'b1;
        end

        r.out_byte      = c;
        r.ends_sentence = closes;
        r.dropped       = drop_next;
        r.last_out      = 1'b0;
        drop_next       = closes;

        back[2] = back[1];
        back[1] = back[0];
        back[0] = c;
        if (pos_cnt < 3)
            pos_cnt++;
        ahead[0] = ahead[1];
        ahead[1] = ahead[2];
        ahead[2] = 8'h00;
        if (ahead_cnt > 0)
            ahead_cnt--;
        return r;
    endfunction

    // Queue the results one accepted byte releases
    function automatic void predict_marks(in_item_t it);
        out_item_t r;
        int        produced;
        if (ahead_cnt > 2)
            ahead_cnt = 2;
        ahead[ahead_cnt] = it.text_byte;
        ahead_cnt++;
        if (!it.end_of_text)
        begin
            if (ahead_cnt == 3)
                expected_marks.push_back(settle_oldest(1'b1, 1'b1));
            return;
        end
        // Flush the window on end of text
        produced = 0;
        while (ahead_cnt > 0 && produced < 3)
        begin
            r = settle_oldest(ahead_cnt >= 2, ahead_cnt >= 3);
            produced++;
            if (ahead_cnt == 0 || produced == 3)
                r.last_out = 1'b1;
            expected_marks.push_back(r);
        end
        clear_window();
    endfunction

    // Mostly none, sometimes short, rarely long
    function automatic int pause_len();
        int r;
        if (idle_mode == 0)
            return 0;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // Compare one result transfer with the oldest prediction
    task automatic check_mark(out_item_t got);
        out_item_t want;
        if (expected_marks.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result, byte %02h", got.out_byte));
            return;
        end
        want = expected_marks.pop_front();
        if (got.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte got %02h want %02h",
                                      got.out_byte, want.out_byte));
        if (got.ends_sentence !== want.ends_sentence)
            report_mismatch($sformatf("ends_sentence got %b want %b on byte %02h",
                                      got.ends_sentence, want.ends_sentence, want.out_byte));
        if (got.dropped !== want.dropped)
            report_mismatch($sformatf("dropped got %b want %b on byte %02h",
                                      got.dropped, want.dropped, want.out_byte));
        if (got.last_out !== want.last_out)
            report_mismatch($sformatf("last_out got %b want %b on byte %02h",
                                      got.last_out, want.last_out, want.out_byte));
    endtask

    // Sample mid-cycle, act on the transfer at the next edge
    always
    begin
        @(negedge clk);
        seen_valid = mark_valid;
        seen_stall = mark_stall;
        seen_item  = mark_data;
        @(posedge clk);
        if (rst_n && seen_valid === 1'b1 && seen_stall === 1'b0)
            check_mark(seen_item);
    end

    // Stall the result side in random bursts
    always @(posedge clk)
    begin
        if (!rst_n)
            mark_stall <= 1'b0;
        else
        begin
            if (hold_left == 0)
                hold_left = pause_len();
            if (hold_left != 0)
            begin
                mark_stall <= 1'b1;
                hold_left--;
            end
            else
                mark_stall <= 1'b0;
        end
    end

    // Offer one byte and hold it until the transfer
    task automatic send_byte(logic [7:0] b, logic close);
        in_item_t it;
        int       gap;
        logic     stalled;
        it.text_byte   = b;
        it.end_of_text = close;
        gap = pause_len();
        if (gap != 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_valid <= 1'b1;
        text_data  <= it;
        do
        begin
            @(negedge clk);
            stalled = text_stall;
            @(posedge clk);
        end
        while (stalled !== 1'b0);
        predict_marks(it);
    endtask

    task automatic add_str(string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    // Send the buffered text, end of text on its last byte
    task automatic send_text_buf();
        for (int i = 0; i < text_buf.size(); i++)
            send_byte(text_buf[i], i == text_buf.size() - 1);
    endtask

    task automatic send_text(string s);
        text_buf.delete();
        add_str(s);
        send_text_buf();
    endtask

    function automatic logic [7:0] any_mark();
        case ($urandom_range(0, 2))
            0:       return CH_PERIOD;
            1:       return CH_QUESTION;
            default: return CH_BANG;
        endcase
    endfunction

    // Build a text: mostly sentences with random content, some pure noise
    task automatic build_text();
        int want_len;
        int pick;
        int k;
        text_buf.delete();
        want_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 16);
        if ($urandom_range(0, 4) == 0)
        begin
            repeat (want_len) text_buf.push_back(8'($urandom_range(0, 255)));
            return;
        end
        while (text_buf.size() < want_len)
        begin
            pick = $urandom_range(0, 11);
            if (pick < 4)
            begin
                k = $urandom_range(1, 5);
                if ($urandom_range(0, 1) == 0)
                    text_buf.push_back(8'($urandom_range(CH_UPPER_A, CH_UPPER_Z)));
                else
                    text_buf.push_back(8'($urandom_range(CH_LOWER_A, CH_LOWER_Z)));
                repeat (k - 1) text_buf.push_back(8'($urandom_range(CH_LOWER_A, CH_LOWER_Z)));
            end
            else if (pick < 6)
            begin
                if ($urandom_range(0, 3) == 0)
                    text_buf.push_back(8'($urandom_range(CH_TAB, CH_CR)));
                else
                    text_buf.push_back(CH_SPACE);
            end
            else if (pick < 8)
            begin
                text_buf.push_back(any_mark());
                repeat ($urandom_range(0, 3) / 2 * $urandom_range(1, 2))
                    text_buf.push_back(CH_PERIOD);
            end
            else if (pick == 8)
            begin
                case ($urandom_range(0, 3))
                    0:       add_str("Mr.");
                    1:       add_str("Mrs.");
                    2:       add_str("Dr.");
                    default: add_str("Jr.");
                endcase
            end
            else if (pick == 9)
                repeat ($urandom_range(1, 3))
                    text_buf.push_back(8'($urandom_range(CH_DIGIT_0, CH_DIGIT_9)));
            else if (pick == 10)
                text_buf.push_back(CH_COMMA);
            else
                text_buf.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Single-byte text, mark at position 0, empty sentences, lookahead past the end
    task automatic test_window_edges();
        idle_mode = 0;
        send_text(".");
        send_text("A.!?");
    endtask

    // Periods after Jr and Mrs never close a sentence
    task automatic test_titles();
        idle_mode = 0;
        send_text("Jr.Mrs.");
    endtask

    // The rejection rules other than titles, a period run, a high byte and a zero byte at the end
    task automatic test_rejections();
        idle_mode = 1;
        text_buf.delete();
        add_str("x. b!2c.d?,e..");
        text_buf.push_back(8'hFF);
        text_buf.push_back(8'h00);
        send_text_buf();
    endtask

    task automatic test_random_texts(int target, int mode);
        int sent;
        idle_mode = mode;
        sent = 0;
        while (sent < target)
        begin
            build_text();
            send_text_buf();
            sent += text_buf.size();
        end
    endtask

    initial
    begin
        clear_window();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_window_edges();
        test_titles();
        test_rejections();
        test_random_texts(80, 1);
        test_random_texts(30, 0);
        test_random_texts(30, 1);

        // Let the remaining results drain
        text_valid <= 1'b0;
        while (expected_marks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sentence_boundary_marker_core.f =====
+incdir+src
src/sbm_pkg.sv
src/sbm_in_stage.sv
src/sbm_window.sv
src/sbm_out_stage.sv
src/sentence_boundary_marker_core.sv
src/sbm_checker.sv
bench/sentence_boundary_marker_core_tb.sv
